// ----- rtl/core/triggered_light_fade_timer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Triggered light fade timer: assertion macros
// Shared macros for the concurrent checks of the fade timer.
// ----------------------------------------------------------------------------
`ifndef TRIGGERED_LIGHT_FADE_TIMER_UNIT_DEFINES_SVH
`define TRIGGERED_LIGHT_FADE_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fade timer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TLFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fade timer check failed");

`endif

// ----- rtl/core/tlft_pkg.sv -----
// ----------------------------------------------------------------------------
// Triggered light fade timer package
// Types and codes shared by the fade timer modules.
// ----------------------------------------------------------------------------
package tlft_pkg;

    // Lamp mode, also the state of the fade state machine.
    typedef enum logic [1:0] {
        MODE_STATIC  = 2'd0,
        MODE_RISING  = 2'd1,
        MODE_FALLING = 2'd2
    } t_mode;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_ENABLE  = 2'd2
    } t_op;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAX_LEVEL    = 2'd0,
        CFG_HOLD_TICKS   = 2'd1,
        CFG_EXTEND_LIMIT = 2'd2
    } t_cfg_index;

    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned HOLD_CNT_W = 17;
    localparam int unsigned EXTEND_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST    = 8'd255;
    localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST   = 16'd1000;
    localparam logic [EXTEND_W-1:0] EXTEND_LIMIT_RST = 8'd10;

    typedef struct packed {
        logic [LEVEL_W-1:0]  max_level;
        logic [HOLD_W-1:0]   hold_ticks;
        logic [EXTEND_W-1:0] extend_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0] operation;
        logic       trigger_level;
        logic       enable_value;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               level_written;
        t_mode              mode;
    } t_result;

endpackage

// ----- rtl/core/tlft_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Fade timer configuration registers
// Holds full level, hold time and extension limit, written by index.
// ----------------------------------------------------------------------------
module tlft_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [1:0]                        i_wr_index,
    input  logic [tlft_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output tlft_pkg::t_cfg                    o_cfg
);

    tlft_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_level    <= tlft_pkg::MAX_LEVEL_RST;
            r_cfg.hold_ticks   <= tlft_pkg::HOLD_TICKS_RST;
            r_cfg.extend_limit <= tlft_pkg::EXTEND_LIMIT_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                tlft_pkg::CFG_MAX_LEVEL: begin
                    r_cfg.max_level <= i_wr_data[tlft_pkg::LEVEL_W-1:0];
                end
                tlft_pkg::CFG_HOLD_TICKS: begin
                    r_cfg.hold_ticks <= i_wr_data[tlft_pkg::HOLD_W-1:0];
                end
                tlft_pkg::CFG_EXTEND_LIMIT: begin
                    r_cfg.extend_limit <= i_wr_data[tlft_pkg::EXTEND_W-1:0];
                end
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/tlft_core.sv -----
// ----------------------------------------------------------------------------
// Fade timer core
// Lamp state registers and the next-state logic for one beat.
// ----------------------------------------------------------------------------
module tlft_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  tlft_pkg::t_item   i_item,
    input  tlft_pkg::t_cfg    i_cfg,
    output tlft_pkg::t_result o_result
);

    tlft_pkg::t_mode                       r_mode, n_mode;
    logic [tlft_pkg::LEVEL_W-1:0]          r_level, n_level;
    logic [tlft_pkg::HOLD_CNT_W-1:0]       r_hold, n_hold;
    logic [tlft_pkg::EXTEND_W-1:0]         r_ext, n_ext;
    logic                                  r_enabled, n_enabled;
    logic                                  written;

    logic                                  full;
    logic                                  dark;
    logic [tlft_pkg::HOLD_CNT_W-1:0]       hold_lim;
    logic                                  hold_done;
    logic                                  trig_hit;

    assign full      = (r_level >= i_cfg.max_level);
    assign dark      = (r_level == '0);
    assign hold_lim  = {1'b0, i_cfg.hold_ticks}
                     + {{(tlft_pkg::HOLD_CNT_W - tlft_pkg::EXTEND_W){1'b0}}, r_ext};
    assign hold_done = (r_hold >= hold_lim);
    assign trig_hit  = r_enabled && !i_item.trigger_level;

    // Next state of the mode machine.
    always_comb begin
        n_mode = r_mode;
        unique case (i_item.operation)
            tlft_pkg::OP_TICK: begin
                unique case (r_mode)
                    tlft_pkg::MODE_STATIC: begin
                        if (hold_done) n_mode = tlft_pkg::MODE_FALLING;
                    end
                    tlft_pkg::MODE_RISING: begin
                        if (full) n_mode = tlft_pkg::MODE_STATIC;
                    end
                    tlft_pkg::MODE_FALLING: begin
                        if (dark) n_mode = tlft_pkg::MODE_STATIC;
                    end
                    default: begin
                    end
                endcase
            end
            tlft_pkg::OP_TRIGGER: begin
                if (trig_hit) begin
                    if (r_mode == tlft_pkg::MODE_STATIC && dark) begin
                        n_mode = tlft_pkg::MODE_RISING;
                    end else if (r_mode == tlft_pkg::MODE_FALLING) begin
                        n_mode = tlft_pkg::MODE_RISING;
                    end
                end
            end
            tlft_pkg::OP_ENABLE: begin
                if (!i_item.enable_value) n_mode = tlft_pkg::MODE_FALLING;
            end
            default: begin
            end
        endcase
    end

    // Level, counters and enable.
    always_comb begin
        n_level   = r_level;
        n_hold    = r_hold;
        n_ext     = r_ext;
        n_enabled = r_enabled;
        written   = 1'b0;
        unique case (i_item.operation)
            tlft_pkg::OP_TICK: begin
                unique case (r_mode)
                    tlft_pkg::MODE_STATIC: begin
                        if (hold_done) begin
                            n_hold = '0;
                            n_ext  = '0;
                        end else if (!dark && full) begin
                            n_hold = r_hold + 1'b1;
                        end
                    end
                    tlft_pkg::MODE_RISING: begin
                        if (!full) begin
                            n_level = r_level + 1'b1;
                            written = 1'b1;
                        end
                    end
                    tlft_pkg::MODE_FALLING: begin
                        if (dark) begin
                            n_hold = '0;
                            n_ext  = '0;
                        end else begin
                            n_level = r_level - 1'b1;
                            written = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tlft_pkg::OP_TRIGGER: begin
                if (trig_hit) begin
                    if (r_mode == tlft_pkg::MODE_STATIC && !dark) begin
                        n_hold = '0;
                        if (r_ext < i_cfg.extend_limit) n_ext = r_ext + 1'b1;
                    end else if (r_mode == tlft_pkg::MODE_FALLING) begin
                        n_hold = '0;
                    end
                end
            end
            tlft_pkg::OP_ENABLE: begin
                n_enabled = i_item.enable_value;
                if (!i_item.enable_value) begin
                    n_hold = '0;
                    n_ext  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= tlft_pkg::MODE_STATIC;
            r_level   <= '0;
            r_hold    <= '0;
            r_ext     <= '0;
            r_enabled <= 1'b1;
        end else if (i_adv) begin
            r_mode    <= n_mode;
            r_level   <= n_level;
            r_hold    <= n_hold;
            r_ext     <= n_ext;
            r_enabled <= n_enabled;
        end
    end

    assign o_result.level         = n_level;
    assign o_result.level_written = written;
    assign o_result.mode          = n_mode;

endmodule

// ----- rtl/core/triggered_light_fade_timer_unit.sv -----
// ----------------------------------------------------------------------------
// Triggered light fade timer unit
// Lamp dimmer with rise, hold and fade driven by tick, trigger and enable beats.
// ----------------------------------------------------------------------------
// Usage: each input beat carries an operation (tick, trigger sample or enable
// write) with its trigger level and enable value. Every beat yields exactly
// one result beat carrying the lamp level, a flag showing that the level was
// changed, and the mode left behind by the beat.
// Both the input and the result channel use valid and stall; a beat moves at
// an edge where valid is high and stall is low.
// A beat is registered on acceptance; as it leaves the input register the
// lamp state is updated and the result registered. Throughput is one beat
// per cycle while the result side does not stall, limited only by the single
// pass through the next-state logic between the input and result registers.
// When the receiver stalls, the held result stays put and one more beat may
// still be taken into the input register; input stall rises only when both
// registers are full and the result side is stalled.
// The configuration channel (valid and ready, always ready) writes full
// level, hold time and extension limit by index, and is meant to be used
// while the unit is idle. Reset returns the lamp to dark, static, enabled,
// with both counters cleared and the registers at their default values.
// ----------------------------------------------------------------------------
`include "triggered_light_fade_timer_unit_defines.svh"

module triggered_light_fade_timer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_operation,
    input  logic                             i_trigger_level,
    input  logic                             i_enable_value,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_level,
    output logic                             o_level_written,
    output logic [1:0]                       o_mode,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [tlft_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    tlft_pkg::t_cfg    cfg;
    tlft_pkg::t_item   r_item;
    tlft_pkg::t_result core_result;
    tlft_pkg::t_result r_result;

    logic r_in_valid, n_in_valid;
    logic r_out_valid, n_out_valid;
    logic in_accept;
    logic adv;

    // The configuration registers never hold a write back.
    assign o_cfg_ready = 1'b1;

    tlft_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The input register empties into the result register whenever that one
    // is empty or is being read in the same cycle.
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign n_in_valid  = in_accept || (r_in_valid && !adv);
    assign n_out_valid = adv || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.operation     <= i_operation;
            r_item.trigger_level <= i_trigger_level;
            r_item.enable_value  <= i_enable_value;
        end
        if (adv) begin
            r_result <= core_result;
        end
    end

    // Lamp state advances exactly once per beat, as it leaves the input
    // register, so back-to-back beats see each other's updates in order.
    tlft_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_level         = r_result.level;
    assign o_level_written = r_result.level_written;
    assign o_mode          = r_result.mode;

    // A beat that leaves the input register is on offer at the next edge.
    `TLFT_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, adv, o_out_valid)

    // The input side holds back only when the result side is full and stalled.
    `TLFT_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        o_out_valid && i_out_stall && r_in_valid)

    // The level only changes while the lamp is ramping.
    `TLFT_ASSERT_NOW(a_write_while_ramping, i_clk, i_rst_n,
        o_out_valid && o_level_written,
        o_mode == tlft_pkg::MODE_RISING || o_mode == tlft_pkg::MODE_FALLING)

endmodule

// ----- verif/tb_triggered_light_fade_timer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade timer unit testbench
// Drives tick, trigger and enable beats into the lamp dimmer with random gaps
// and stalls on both channels, reprograms the full level, hold time and
// extension limit between phases, and checks every result beat against a
// typed value or a behavioural copy of the lamp held inside the bench.
// ----------------------------------------------------------------------------
module tb_triggered_light_fade_timer_unit;

    // Operation code 3 has no meaning in the unit; it must leave the lamp alone.
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int SETTLE_CYCLES  = 4;     // pipeline settling plus margin
    localparam int WATCHDOG_LIMIT = 1000;  // quiet cycles before giving up
    localparam int PRESSURE_AFTER = 60;    // result count that starts the hold-off
    localparam int PRESSURE_HOLD  = 90;    // length of the long receiver hold-off

    // ------------------------------------------------------------------------
    // Signals towards and from the unit. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_in_valid      = 1'b0;
    logic                            o_in_stall;
    logic [1:0]                      i_operation     = tlft_pkg::OP_TICK;
    logic                            i_trigger_level = 1'b1;
    logic                            i_enable_value  = 1'b1;
    logic                            o_out_valid;
    logic                            i_out_stall     = 1'b1;
    logic [7:0]                      o_level;
    logic                            o_level_written;
    logic [1:0]                      o_mode;
    logic                            i_cfg_valid     = 1'b0;
    logic                            o_cfg_ready;
    logic [1:0]                      i_cfg_index     = tlft_pkg::CFG_MAX_LEVEL;
    logic [tlft_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;

    triggered_light_fade_timer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_trigger_level (i_trigger_level),
        .i_enable_value  (i_enable_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_level         (o_level),
        .o_level_written (o_level_written),
        .o_mode          (o_mode),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------------
    // Lamp shadow. These variables follow the unit's registers and state beat
    // by beat; they start at the reset values because reset happens only once.
    // ------------------------------------------------------------------------
    logic [tlft_pkg::LEVEL_W-1:0]    lamp_max_level    = tlft_pkg::MAX_LEVEL_RST;
    logic [tlft_pkg::HOLD_W-1:0]     lamp_hold_ticks   = tlft_pkg::HOLD_TICKS_RST;
    logic [tlft_pkg::EXTEND_W-1:0]   lamp_extend_limit = tlft_pkg::EXTEND_LIMIT_RST;
    tlft_pkg::t_mode                 lamp_mode         = tlft_pkg::MODE_STATIC;
    logic [tlft_pkg::LEVEL_W-1:0]    lamp_level        = '0;
    logic [tlft_pkg::HOLD_CNT_W-1:0] lamp_hold_count   = '0;
    logic [tlft_pkg::EXTEND_W-1:0]   lamp_extend_count = '0;
    logic                            lamp_enabled      = 1'b1;

    // Results still owed by the unit, oldest first.
    tlft_pkg::t_result expected_lamp_results [$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int tx_idle_max    = 17;
    int rx_idle_max    = 17;
    int quiet_cycles   = 0;

    // Applies one beat to the shadow lamp and returns the result it should give.
    function automatic tlft_pkg::t_result predict_lamp_step(input tlft_pkg::t_item item);
        tlft_pkg::t_result res;
        logic              full;
        logic              written;
        logic [17:0]       hold_limit;
        // The lamp counts as full at or above the full level, so a lowered
        // full level ends a rise at once instead of wrapping the level.
        full       = (lamp_level >= lamp_max_level);
        written    = 1'b0;
        hold_limit = {2'b00, lamp_hold_ticks} + {10'd0, lamp_extend_count};
        case (item.operation)
            tlft_pkg::OP_TICK: begin
                case (lamp_mode)
                    tlft_pkg::MODE_STATIC: begin
                        // The hold check also runs while dark, and a count left
                        // above a lowered limit ends the hold on this tick.
                        if ({1'b0, lamp_hold_count} >= hold_limit) begin
                            lamp_hold_count   = '0;
                            lamp_extend_count = '0;
                            lamp_mode         = tlft_pkg::MODE_FALLING;
                        end else if (lamp_level != '0 && full) begin
                            lamp_hold_count = lamp_hold_count + 1'b1;
                        end
                    end
                    tlft_pkg::MODE_RISING: begin
                        if (full) begin
                            lamp_mode = tlft_pkg::MODE_STATIC;
                        end else begin
                            lamp_level = lamp_level + 1'b1;
                            written    = 1'b1;
                        end
                    end
                    tlft_pkg::MODE_FALLING: begin
                        if (lamp_level == '0) begin
                            lamp_mode         = tlft_pkg::MODE_STATIC;
                            lamp_hold_count   = '0;
                            lamp_extend_count = '0;
                        end else begin
                            lamp_level = lamp_level - 1'b1;
                            written    = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            tlft_pkg::OP_TRIGGER: begin
                // The sensor is active low; a disabled lamp ignores it, and so
                // does a lamp that is already rising.
                if (lamp_enabled && !item.trigger_level) begin
                    if (lamp_mode == tlft_pkg::MODE_STATIC) begin
                        if (lamp_level == '0) begin
                            lamp_mode = tlft_pkg::MODE_RISING;
                        end else begin
                            lamp_hold_count = '0;
                            // An extension already above a lowered limit is kept.
                            if (lamp_extend_count < lamp_extend_limit)
                                lamp_extend_count = lamp_extend_count + 1'b1;
                        end
                    end else if (lamp_mode == tlft_pkg::MODE_FALLING) begin
                        lamp_hold_count = '0;
                        lamp_mode       = tlft_pkg::MODE_RISING;
                    end
                end
            end
            tlft_pkg::OP_ENABLE: begin
                lamp_enabled = item.enable_value;
                if (!lamp_enabled) begin
                    lamp_mode         = tlft_pkg::MODE_FALLING;
                    lamp_hold_count   = '0;
                    lamp_extend_count = '0;
                end
            end
            default: ;
        endcase
        res.level         = lamp_level;
        res.level_written = written;
        res.mode          = lamp_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Each call starts at a falling edge and returns at the falling
    // edge after the beat was taken, with valid still high; the caller either
    // offers the next beat at once or lowers valid in the same step.
    // ------------------------------------------------------------------------
    task automatic send_item(input tlft_pkg::t_item item, input logic typed,
                             input tlft_pkg::t_result typed_result);
        int                gap;
        tlft_pkg::t_result predicted;
        gap = $urandom_range(0, tx_idle_max);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_operation     = item.operation;
        i_trigger_level = item.trigger_level;
        i_enable_value  = item.enable_value;
        do @(posedge i_clk); while (o_in_stall);
        // The shadow always advances; a row with a result typed into the table
        // is held to that value instead of the computed one.
        predicted = predict_lamp_step(item);
        expected_lamp_results.push_back(typed ? typed_result : predicted);
        @(negedge i_clk);
    endtask

    // Lets every owed result come out and the pipeline settle before a
    // register is touched. Called at a falling edge.
    task automatic wait_until_drained();
        i_in_valid = 1'b0;
        while (expected_lamp_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input tlft_pkg::t_cfg_index index,
                                  input logic [tlft_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            tlft_pkg::CFG_MAX_LEVEL:
                lamp_max_level    = data[tlft_pkg::LEVEL_W-1:0];
            tlft_pkg::CFG_HOLD_TICKS:
                lamp_hold_ticks   = data[tlft_pkg::HOLD_W-1:0];
            tlft_pkg::CFG_EXTEND_LIMIT:
                lamp_extend_limit = data[tlft_pkg::EXTEND_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Compares the result beat taken at this rising edge with the oldest one owed.
    task automatic check_result();
        tlft_pkg::t_result want;
        results_seen++;
        if (expected_lamp_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got level %0d written %0b mode %0d",
                     $time, o_level, o_level_written, o_mode);
            mismatch_count++;
        end else begin
            want = expected_lamp_results.pop_front();
            if (o_level !== want.level) begin
                $display("%0t: level mismatch: expected %0d, got %0d",
                         $time, want.level, o_level);
                mismatch_count++;
            end
            if (o_level_written !== want.level_written) begin
                $display("%0t: level_written mismatch: expected %0b, got %0b",
                         $time, want.level_written, o_level_written);
                mismatch_count++;
            end
            if (o_mode !== want.mode) begin
                $display("%0t: mode mismatch: expected %0d, got %0d",
                         $time, want.mode, o_mode);
                mismatch_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side. Before each beat the receiver draws a random stall, possibly
    // none, up to the phase maximum. Once, some way into the random part, it holds off for a
    // long stretch while the sender keeps offering, so that both internal
    // registers fill and the unit has to stall its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = $urandom_range(0, rx_idle_max);
            if (results_seen == PRESSURE_AFTER)
                hold = PRESSURE_HOLD;
            if (hold != 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            check_result();
            @(negedge i_clk);
        end
    end

    // A run that stops moving beats on every channel is declared dead.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_triggered_light_fade_timer_unit: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. Item rows carry a typed result only where it is plain
    // from the reset state; register rows are written once the unit is idle.
    // ------------------------------------------------------------------------
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [1:0]                      operation;
        logic                            trigger_level;
        logic                            enable_value;
        tlft_pkg::t_cfg_index            cfg_index;
        logic [tlft_pkg::CFG_DATA_W-1:0] cfg_data;
        logic                            typed;
        tlft_pkg::t_result               result;
    } t_stim_row;

    t_stim_row directed_rows [$] = '{
        // Straight after reset: dark, static, enabled, registers at defaults.
        // A dark static tick does nothing, and nor does the unused code.
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b1, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b1,
          '{8'd0, 1'b0, tlft_pkg::MODE_STATIC}},
        '{ROW_ITEM, OP_NOP, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b1,
          '{8'd0, 1'b0, tlft_pkg::MODE_STATIC}},
        // An idle sensor level is ignored; an active one starts a rise from dark.
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b1, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b1,
          '{8'd0, 1'b0, tlft_pkg::MODE_STATIC}},
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b1,
          '{8'd0, 1'b0, tlft_pkg::MODE_RISING}},
        // Disabling forces a fade, and triggers are dropped while disabled.
        '{ROW_ITEM, tlft_pkg::OP_ENABLE, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b1,
          '{8'd0, 1'b0, tlft_pkg::MODE_FALLING}},
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b1,
          '{8'd0, 1'b0, tlft_pkg::MODE_FALLING}},
        '{ROW_ITEM, tlft_pkg::OP_ENABLE, 1'b1, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b1,
          '{8'd0, 1'b0, tlft_pkg::MODE_FALLING}},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b1,
          '{8'd0, 1'b0, tlft_pkg::MODE_STATIC}},
        // A short lamp: full at 2, hold of one tick, one extension allowed.
        '{ROW_CFG, tlft_pkg::OP_TICK, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd2, 1'b0, '0},
        '{ROW_CFG, tlft_pkg::OP_TICK, 1'b0, 1'b0, tlft_pkg::CFG_HOLD_TICKS, 16'd1, 1'b0, '0},
        '{ROW_CFG, tlft_pkg::OP_TICK, 1'b0, 1'b0, tlft_pkg::CFG_EXTEND_LIMIT, 16'd1, 1'b0, '0},
        // Rise to full, with a trigger during the rise that must be ignored.
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b1, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b1, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        // Hold, then two retriggers: the second finds the extension at its limit.
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b1, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b1, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        // Fade one step, then a trigger while falling turns it into a rise.
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b1, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        // A retrigger while held at full takes the extension to its limit of one.
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        // Lower every register to zero while lit: the extension left at one
        // stays above the new limit, and the full level now sits below the lamp.
        '{ROW_CFG, tlft_pkg::OP_TICK, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_CFG, tlft_pkg::OP_TICK, 1'b0, 1'b0, tlft_pkg::CFG_HOLD_TICKS, 16'd0, 1'b0, '0},
        '{ROW_CFG, tlft_pkg::OP_TICK, 1'b0, 1'b0, tlft_pkg::CFG_EXTEND_LIMIT, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b1, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b0, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TRIGGER, 1'b0, 1'b0, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_ITEM, tlft_pkg::OP_TICK, 1'b1, 1'b1, tlft_pkg::CFG_MAX_LEVEL, 16'd0, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Random phases. Each sets the three registers, the share of ticks and the
    // idling on both sides. The long phase at full level 255 is tick heavy so
    // that the lamp climbs all the way and wraps neither way.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [tlft_pkg::LEVEL_W-1:0]  max_level;
        logic [tlft_pkg::HOLD_W-1:0]   hold_ticks;
        logic [tlft_pkg::EXTEND_W-1:0] extend_limit;
        logic                          shuffle;
        int                            items;
        int                            tick_pct;
        int                            tx_idle;
        int                            rx_idle;
    } t_phase_plan;

    t_phase_plan test_phases [$] = '{
        '{8'd4,   16'd3,     8'd2,   1'b0, 100, 75, 0,  17},
        '{8'd255, 16'd0,     8'd255, 1'b0, 300, 95, 17, 17},
        '{8'd0,   16'd65535, 8'd0,   1'b0, 60,  75, 17, 0},
        '{8'd0,   16'd0,     8'd0,   1'b1, 80,  75, 0,  0},
        '{8'd6,   16'd20,    8'd255, 1'b0, 60,  60, 17, 17},
        '{8'd0,   16'd0,     8'd0,   1'b1, 50,  75, 17, 17}
    };

    initial begin : stimulus
        t_phase_plan     plan;
        tlft_pkg::t_item item;
        int              pick;
        int              trigger_bound;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                wait_until_drained();
                write_register(directed_rows[r].cfg_index, directed_rows[r].cfg_data);
            end else begin
                item.operation     = directed_rows[r].operation;
                item.trigger_level = directed_rows[r].trigger_level;
                item.enable_value  = directed_rows[r].enable_value;
                send_item(item, directed_rows[r].typed, directed_rows[r].result);
            end
        end

        foreach (test_phases[p]) begin
            plan = test_phases[p];
            wait_until_drained();
            if (plan.shuffle) begin
                plan.max_level    = 8'($urandom_range(1, 12));
                plan.hold_ticks   = 16'($urandom_range(0, 8));
                plan.extend_limit = 8'($urandom_range(0, 4));
            end
            write_register(tlft_pkg::CFG_MAX_LEVEL,    {8'd0, plan.max_level});
            write_register(tlft_pkg::CFG_HOLD_TICKS,   plan.hold_ticks);
            write_register(tlft_pkg::CFG_EXTEND_LIMIT, {8'd0, plan.extend_limit});
            tx_idle_max   = plan.tx_idle;
            rx_idle_max   = plan.rx_idle;
            // Ticks first, then triggers, then enable writes, and a rare
            // unused code at the top of the range.
            trigger_bound = plan.tick_pct + (100 - plan.tick_pct) * 3 / 4;
            repeat (plan.items) begin
                pick = $urandom_range(0, 99);
                if (pick < plan.tick_pct)
                    item.operation = tlft_pkg::OP_TICK;
                else if (pick < trigger_bound)
                    item.operation = tlft_pkg::OP_TRIGGER;
                else if (pick < 99)
                    item.operation = tlft_pkg::OP_ENABLE;
                else
                    item.operation = OP_NOP;
                // Mostly an active sensor and an enabling write, so the lamp
                // spends its time lit rather than stuck in a forced fade.
                item.trigger_level = ($urandom_range(0, 3) == 0);
                item.enable_value  = ($urandom_range(0, 3) != 0);
                send_item(item, 1'b0, '0);
            end
        end

        wait_until_drained();
        if (mismatch_count == 0) begin
            $display("tb_triggered_light_fade_timer_unit: clean");
        end else begin
            $display("tb_triggered_light_fade_timer_unit: errors");
        end
        $finish;
    end

endmodule
